[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ARPR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("arpr assertion failed");

// clocked check that also holds across reset
`define ARPR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("arpr assertion failed");

`endif

[rtl/arpr_pkg.sv]
package arpr_pkg;

    localparam int FRAME_LEN = 42;
    localparam int IDX_W     = 6;

    localparam logic [IDX_W-1:0] BYTE_IDX_MAX = 6'd63;
    localparam logic [IDX_W-1:0] LAST_IDX     = 6'(FRAME_LEN - 1);

    localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
    localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
    localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  ARP_HLEN       = 8'h06;
    localparam logic [7:0]  ARP_PLEN       = 8'h04;
    localparam logic [7:0]  ARP_OP_HI      = 8'h00;
    localparam logic [7:0]  ARP_OP_REQUEST = 8'h01;
    localparam logic [7:0]  ARP_OP_REPLY   = 8'h02;
    localparam logic [7:0]  BCAST_BYTE     = 8'hff;
    localparam logic [47:0] MAC_BCAST      = 48'hffff_ffff_ffff;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_IP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 3'd4;

    localparam logic [47:0] RST_LOCAL_MAC     = 48'd0;
    localparam logic [31:0] RST_LOCAL_IP      = 32'd3232235876;
    localparam logic [31:0] RST_PEER_IP       = 32'd3232235777;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;
    localparam logic [7:0]  RST_RETRY_LIMIT   = 8'd5;

    typedef enum logic [1:0] {
        REQ_RX_BYTE,
        REQ_TICK,
        REQ_LINK_UP,
        REQ_LINK_DOWN
    } req_type_t;

    typedef enum logic [1:0] {
        OUT_TX_BYTE,
        OUT_PEER_MAC,
        OUT_GIVE_UP
    } out_kind_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_REQUESTING,
        CTL_RESOLVED
    } ctl_state_t;

    typedef enum logic [1:0] {
        CMD_FRAME,
        CMD_RESOLVED,
        CMD_GIVE_UP
    } cmd_kind_t;

    // one pending result job: a 42-byte arp frame or a single status word
    typedef struct packed {
        cmd_kind_t   kind;
        logic        reply;
        logic [47:0] mac;
        logic [31:0] ip;
    } cmd_t;

    typedef struct packed {
        logic [47:0] local_mac;
        logic [31:0] local_ip;
        logic [31:0] peer_ip;
        logic [15:0] timeout_ticks;
        logic [7:0]  retry_limit;
    } cfg_t;

    // byte idx of the outgoing arp frame, msb first
    function automatic logic [7:0] frame_byte(
        input logic [IDX_W-1:0] idx,
        input cmd_t             cmd,
        input logic [47:0]      local_mac,
        input logic [31:0]      local_ip
    );
        logic [FRAME_LEN*8-1:0] frame;
        logic [47:0]            dst;
        logic [47:0]            tmac;
        logic [7:0]             op;
        logic [IDX_W-1:0]       pos;
        dst   = cmd.reply ? cmd.mac : MAC_BCAST;
        tmac  = cmd.reply ? cmd.mac : 48'd0;
        op    = cmd.reply ? ARP_OP_REPLY : ARP_OP_REQUEST;
        frame = {dst, local_mac, ETH_TYPE_ARP, ARP_HTYPE_ETH, ARP_PTYPE_IPV4,
                 ARP_HLEN, ARP_PLEN, ARP_OP_HI, op, local_mac, local_ip, tmac, cmd.ip};
        pos   = LAST_IDX - idx;
        return frame[{pos, 3'b000} +: 8];
    endfunction

endpackage

[rtl/arpr_rx.sv]
module arpr_rx (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  arpr_pkg::req_type_t req_type,
    input  logic [7:0]         rx_byte,
    input  logic               rx_last,
    input  arpr_pkg::cfg_t     cfg,
    output logic               cmd_valid,
    output arpr_pkg::cmd_t     cmd
);

    localparam logic [5:0] OFS_DST_END  = 6'd6;
    localparam logic [5:0] OFS_TYPE_HI  = 6'd12;
    localparam logic [5:0] OFS_TYPE_LO  = 6'd13;
    localparam logic [5:0] OFS_OP       = 6'd21;
    localparam logic [5:0] OFS_SHA      = 6'd22;
    localparam logic [5:0] OFS_SPA      = 6'd28;
    localparam logic [5:0] OFS_SPA_END  = 6'd32;
    localparam logic [5:0] OFS_TPA      = 6'd38;
    localparam logic [5:0] OFS_TPA_END  = 6'd42;

    arpr_pkg::ctl_state_t ctl_state_reg, ctl_state_next;
    logic [5:0]  byte_index_reg, byte_index_next;
    logic        dest_local_ok_reg, dest_local_ok_next;
    logic        dest_bcast_ok_reg, dest_bcast_ok_next;
    logic [15:0] frame_type_reg, frame_type_next;
    logic [7:0]  arp_op_reg, arp_op_next;
    logic [47:0] sender_mac_reg, sender_mac_next;
    logic [31:0] sender_ip_reg, sender_ip_next;
    logic [31:0] target_ip_reg, target_ip_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  sends_done_reg, sends_done_next;

    logic [2:0]  mac_pos;
    logic [15:0] tick_inc;
    logic        frame_ok;
    logic        answer_req;
    logic        peer_reply;
    logic        send_req;
    logic        give_up;

    // receive parser
    always_comb begin
        byte_index_next    = byte_index_reg;
        dest_local_ok_next = dest_local_ok_reg;
        dest_bcast_ok_next = dest_bcast_ok_reg;
        frame_type_next    = frame_type_reg;
        arp_op_next        = arp_op_reg;
        sender_mac_next    = sender_mac_reg;
        sender_ip_next     = sender_ip_reg;
        target_ip_next     = target_ip_reg;
        frame_ok           = 1'b0;
        answer_req         = 1'b0;
        peer_reply         = 1'b0;
        mac_pos            = 3'd5 - byte_index_reg[2:0];
        if (req_type == arpr_pkg::REQ_RX_BYTE) begin
            if (byte_index_reg < OFS_DST_END) begin
                if (rx_byte != cfg.local_mac[{mac_pos, 3'b000} +: 8]) begin
                    dest_local_ok_next = 1'b0;
                end
                if (rx_byte != arpr_pkg::BCAST_BYTE) begin
                    dest_bcast_ok_next = 1'b0;
                end
            end else if (byte_index_reg == OFS_TYPE_HI || byte_index_reg == OFS_TYPE_LO) begin
                frame_type_next = {frame_type_reg[7:0], rx_byte};
            end else if (byte_index_reg == OFS_OP) begin
                arp_op_next = rx_byte;
            end else if (byte_index_reg >= OFS_SHA && byte_index_reg < OFS_SPA) begin
                sender_mac_next = {sender_mac_reg[39:0], rx_byte};
            end else if (byte_index_reg >= OFS_SPA && byte_index_reg < OFS_SPA_END) begin
                sender_ip_next = {sender_ip_reg[23:0], rx_byte};
            end else if (byte_index_reg >= OFS_TPA && byte_index_reg < OFS_TPA_END) begin
                target_ip_next = {target_ip_reg[23:0], rx_byte};
            end
            if (byte_index_reg != arpr_pkg::BYTE_IDX_MAX) begin
                byte_index_next = byte_index_reg + 6'd1;
            end
            if (rx_last) begin
                frame_ok = (byte_index_next >= 6'(arpr_pkg::FRAME_LEN))
                        && (dest_local_ok_next || dest_bcast_ok_next)
                        && (frame_type_next == arpr_pkg::ETH_TYPE_ARP);
                answer_req = frame_ok && (arp_op_next == arpr_pkg::ARP_OP_REQUEST)
                          && (target_ip_next == cfg.local_ip);
                peer_reply = frame_ok && (arp_op_next == arpr_pkg::ARP_OP_REPLY)
                          && (sender_ip_next == cfg.peer_ip);
                byte_index_next    = '0;
                dest_local_ok_next = 1'b1;
                dest_bcast_ok_next = 1'b1;
            end
        end
    end

    // resolver control, next state
    always_comb begin
        ctl_state_next  = ctl_state_reg;
        elapsed_next    = elapsed_reg;
        sends_done_next = sends_done_reg;
        send_req        = 1'b0;
        give_up         = 1'b0;
        tick_inc        = (elapsed_reg != '1) ? elapsed_reg + 16'd1 : elapsed_reg;
        unique case (req_type)
            arpr_pkg::REQ_RX_BYTE: begin
                if (peer_reply) begin
                    ctl_state_next = arpr_pkg::CTL_RESOLVED;
                end
            end
            arpr_pkg::REQ_TICK: begin
                if (ctl_state_reg == arpr_pkg::CTL_REQUESTING) begin
                    elapsed_next = tick_inc;
                    if (tick_inc >= cfg.timeout_ticks) begin
                        if (sends_done_reg < cfg.retry_limit) begin
                            sends_done_next = sends_done_reg + 8'd1;
                            elapsed_next    = '0;
                            send_req        = 1'b1;
                        end else begin
                            give_up        = 1'b1;
                            ctl_state_next = arpr_pkg::CTL_IDLE;
                        end
                    end
                end
            end
            arpr_pkg::REQ_LINK_UP: begin
                ctl_state_next  = arpr_pkg::CTL_REQUESTING;
                elapsed_next    = '0;
                sends_done_next = 8'd1;
                send_req        = 1'b1;
            end
            arpr_pkg::REQ_LINK_DOWN: begin
                ctl_state_next = arpr_pkg::CTL_IDLE;
            end
        endcase
    end

    // result job for the transmit side
    always_comb begin
        cmd_valid  = answer_req || peer_reply || send_req || give_up;
        cmd.kind   = arpr_pkg::CMD_FRAME;
        cmd.reply  = 1'b0;
        cmd.mac    = '0;
        cmd.ip     = cfg.peer_ip;
        priority if (answer_req) begin
            cmd.reply = 1'b1;
            cmd.mac   = sender_mac_next;
            cmd.ip    = sender_ip_next;
        end else if (peer_reply) begin
            cmd.kind = arpr_pkg::CMD_RESOLVED;
            cmd.mac  = sender_mac_next;
        end else if (give_up) begin
            cmd.kind = arpr_pkg::CMD_GIVE_UP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_state_reg     <= arpr_pkg::CTL_IDLE;
            byte_index_reg    <= '0;
            dest_local_ok_reg <= 1'b1;
            dest_bcast_ok_reg <= 1'b1;
            frame_type_reg    <= '0;
            arp_op_reg        <= '0;
            sender_mac_reg    <= '0;
            sender_ip_reg     <= '0;
            target_ip_reg     <= '0;
            elapsed_reg       <= '0;
            sends_done_reg    <= '0;
        end else if (in_accept) begin
            ctl_state_reg     <= ctl_state_next;
            byte_index_reg    <= byte_index_next;
            dest_local_ok_reg <= dest_local_ok_next;
            dest_bcast_ok_reg <= dest_bcast_ok_next;
            frame_type_reg    <= frame_type_next;
            arp_op_reg        <= arp_op_next;
            sender_mac_reg    <= sender_mac_next;
            sender_ip_reg     <= sender_ip_next;
            target_ip_reg     <= target_ip_next;
            elapsed_reg       <= elapsed_next;
            sends_done_reg    <= sends_done_next;
        end
    end

endmodule

[rtl/arpr_tx.sv]
`include "assert_macros.svh"

module arpr_tx (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  arpr_pkg::cmd_t           cmd_in,
    output logic                     in_ready,
    input  logic [47:0]              local_mac,
    input  logic [31:0]              local_ip,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output arpr_pkg::out_kind_t      m_kind,
    output logic [7:0]               m_byte,
    output logic                     m_last,
    output logic [47:0]              m_mac
);

    arpr_pkg::cmd_t cmd_reg;
    logic           cmd_valid_reg;
    logic [arpr_pkg::IDX_W-1:0] idx_reg;

    logic                out_valid_reg;
    arpr_pkg::out_kind_t out_kind_reg, out_kind_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;
    logic [47:0]         out_mac_reg, out_mac_next;

    logic out_free;
    logic emit;
    logic last_step;
    logic drain;

    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = cmd_valid_reg && out_free;
    assign last_step = (cmd_reg.kind != arpr_pkg::CMD_FRAME) || (idx_reg == arpr_pkg::LAST_IDX);
    assign drain     = emit && last_step;
    assign in_ready  = !cmd_valid_reg || drain;

    always_comb begin
        out_kind_next = arpr_pkg::OUT_TX_BYTE;
        out_byte_next = '0;
        out_last_next = 1'b0;
        out_mac_next  = '0;
        unique case (cmd_reg.kind)
            arpr_pkg::CMD_FRAME: begin
                out_byte_next = arpr_pkg::frame_byte(idx_reg, cmd_reg, local_mac, local_ip);
                out_last_next = (idx_reg == arpr_pkg::LAST_IDX);
            end
            arpr_pkg::CMD_RESOLVED: begin
                out_kind_next = arpr_pkg::OUT_PEER_MAC;
                out_mac_next  = cmd_reg.mac;
            end
            arpr_pkg::CMD_GIVE_UP: begin
                out_kind_next = arpr_pkg::OUT_GIVE_UP;
            end
            default: begin
                out_kind_next = arpr_pkg::OUT_TX_BYTE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                cmd_valid_reg <= 1'b1;
            end else if (drain) begin
                cmd_valid_reg <= 1'b0;
            end
            if (emit && cmd_reg.kind == arpr_pkg::CMD_FRAME) begin
                idx_reg <= last_step ? '0 : idx_reg + 6'd1;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cmd_reg <= cmd_in;
        end
        if (emit) begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_last_reg <= out_last_next;
            out_mac_reg  <= out_mac_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_kind   = out_kind_reg;
    assign m_byte   = out_byte_reg;
    assign m_last   = out_last_reg;
    assign m_mac    = out_mac_reg;

    `ARPR_ASSERT(a_idx_only_in_frame, aclk, aresetn, (idx_reg != '0) |-> (cmd_valid_reg && cmd_reg.kind == arpr_pkg::CMD_FRAME))
    `ARPR_ASSERT(a_last_only_on_bytes, aclk, aresetn, (out_valid_reg && out_last_reg) |-> (out_kind_reg == arpr_pkg::OUT_TX_BYTE))
    `ARPR_ASSERT(a_push_into_free_slot, aclk, aresetn, push |-> in_ready)
    `ARPR_ASSERT(a_frame_wraps, aclk, aresetn, (emit && cmd_reg.kind == arpr_pkg::CMD_FRAME && idx_reg == arpr_pkg::LAST_IDX) |=> (idx_reg == '0 && out_last_reg))
    `ARPR_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> (!out_valid_reg && !cmd_valid_reg))

endmodule

[rtl/arp_responder_resolver.sv]
// result path: a result job goes from the accepting edge into the job slot, then into
//   the output register that drives m_tvalid, which m_tready low can hold up
// throughput: one input word per cycle while the job slot is free or empties; a status
//   result is one output word, an arp frame 42; while a frame is serialized every input
//   word holds off until the last byte is emitted, which m_tready low delays
// reset: aresetn is synchronous, active low; control state and m_tvalid clear and the
//   configuration registers return to their defaults
module arp_responder_resolver (
    input  logic        aclk,
    input  logic        aresetn,

    // received words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic [1:0]  s_tuser,    // [1:0] req_type
    input  logic        s_tlast,    // rx_last

    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [7:0] tx_byte, [55:8] peer_mac
    output logic [1:0]  m_tuser,    // [1:0] out_kind
    output logic        m_tlast,    // tx_last

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    arpr_pkg::cfg_t      cfg_reg;
    logic                in_accept;
    logic                cmd_valid;
    arpr_pkg::cmd_t      cmd;
    logic                cmd_ready;
    arpr_pkg::out_kind_t m_kind;
    logic [7:0]          m_byte;
    logic [47:0]         m_mac;

    // register writes always taken; user keeps block idle whenever they come, unchecked
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.local_mac     <= arpr_pkg::RST_LOCAL_MAC;
            cfg_reg.local_ip      <= arpr_pkg::RST_LOCAL_IP;
            cfg_reg.peer_ip       <= arpr_pkg::RST_PEER_IP;
            cfg_reg.timeout_ticks <= arpr_pkg::RST_TIMEOUT_TICKS;
            cfg_reg.retry_limit   <= arpr_pkg::RST_RETRY_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                arpr_pkg::CFG_LOCAL_MAC:     cfg_reg.local_mac     <= cfg_data;
                arpr_pkg::CFG_LOCAL_IP:      cfg_reg.local_ip      <= cfg_data[31:0];
                arpr_pkg::CFG_PEER_IP:       cfg_reg.peer_ip       <= cfg_data[31:0];
                arpr_pkg::CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[15:0];
                arpr_pkg::CFG_RETRY_LIMIT:   cfg_reg.retry_limit   <= cfg_data[7:0];
                default: begin
                    // unused register index, write dropped
                end
            endcase
        end
    end

    // an input word is taken only when the job slot is free or empties this cycle,
    // whether or not the word causes a result
    assign s_tready  = cmd_ready;
    assign in_accept = s_tvalid && s_tready;

    // parser and resolver control, one word per cycle while s_tready is high
    arpr_rx u_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .req_type  (arpr_pkg::req_type_t'(s_tuser)),
        .rx_byte   (s_tdata),
        .rx_last   (s_tlast),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // job slot, frame serializer and output register
    arpr_tx u_tx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept && cmd_valid),
        .cmd_in    (cmd),
        .in_ready  (cmd_ready),
        .local_mac (cfg_reg.local_mac),
        .local_ip  (cfg_reg.local_ip),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_kind    (m_kind),
        .m_byte    (m_byte),
        .m_last    (m_tlast),
        .m_mac     (m_mac)
    );

    assign m_tdata = {m_mac, m_byte};
    assign m_tuser = m_kind;

endmodule

[bench/tb_arp_responder_resolver.sv]
`timescale 1ns / 100ps

module tb_arp_responder_resolver;

    localparam int HALF_PERIOD  = 6;
    localparam int SETTLE       = 8;     // output register plus margin after the last word
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake on any channel
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int PHASE_WORDS  = 45;

    // one word the block is due to send back
    typedef struct {
        arpr_pkg::out_kind_t kind;
        logic [7:0]          tx_byte;
        logic                tx_last;
        logic [47:0]         peer_mac;
    } tx_word_t;

    // tracks what the responder/resolver must answer and checks its output
    class arp_scoreboard;
        arpr_pkg::cfg_t       regs;
        arpr_pkg::ctl_state_t ctl;
        logic [5:0]  rx_pos;
        bit          dst_local_ok;
        bit          dst_bcast_ok;
        logic [15:0] rx_ethertype;
        logic [7:0]  rx_op;
        logic [47:0] snd_mac;
        logic [31:0] snd_ip;
        logic [31:0] tgt_ip;
        logic [15:0] ticks_waited;
        logic [7:0]  sends;
        tx_word_t    tx_words_due[$];
        int          errors;

        function new();
            regs         = '{arpr_pkg::RST_LOCAL_MAC, arpr_pkg::RST_LOCAL_IP,
                             arpr_pkg::RST_PEER_IP, arpr_pkg::RST_TIMEOUT_TICKS,
                             arpr_pkg::RST_RETRY_LIMIT};
            ctl          = arpr_pkg::CTL_IDLE;
            rx_pos       = '0;
            dst_local_ok = 1'b1;
            dst_bcast_ok = 1'b1;
            rx_ethertype = '0;
            rx_op        = '0;
            snd_mac      = '0;
            snd_ip       = '0;
            tgt_ip       = '0;
            ticks_waited = '0;
            sends        = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] v);
            case (idx)
                arpr_pkg::CFG_LOCAL_MAC:     regs.local_mac     = v;
                arpr_pkg::CFG_LOCAL_IP:      regs.local_ip      = v[31:0];
                arpr_pkg::CFG_PEER_IP:       regs.peer_ip       = v[31:0];
                arpr_pkg::CFG_TIMEOUT_TICKS: regs.timeout_ticks = v[15:0];
                arpr_pkg::CFG_RETRY_LIMIT:   regs.retry_limit   = v[7:0];
                default: ;
            endcase
        endfunction

        function void queue_arp_frame(logic [47:0] dst, logic [7:0] op,
                                      logic [47:0] tmac, logic [31:0] tip);
            logic [arpr_pkg::FRAME_LEN*8-1:0] img;
            tx_word_t                         w;
            img = {dst, regs.local_mac, arpr_pkg::ETH_TYPE_ARP, arpr_pkg::ARP_HTYPE_ETH,
                   arpr_pkg::ARP_PTYPE_IPV4, arpr_pkg::ARP_HLEN, arpr_pkg::ARP_PLEN,
                   arpr_pkg::ARP_OP_HI, op, regs.local_mac, regs.local_ip, tmac, tip};
            for (int i = 0; i < arpr_pkg::FRAME_LEN; i++) begin
                w.kind     = arpr_pkg::OUT_TX_BYTE;
                w.tx_byte  = img[arpr_pkg::FRAME_LEN*8-1-8*i -: 8];
                w.tx_last  = (i == arpr_pkg::FRAME_LEN - 1);
                w.peer_mac = '0;
                tx_words_due.push_back(w);
            end
        endfunction

        function void queue_status(arpr_pkg::out_kind_t kind, logic [47:0] mac);
            tx_word_t w;
            w.kind     = kind;
            w.tx_byte  = '0;
            w.tx_last  = 1'b0;
            w.peer_mac = mac;
            tx_words_due.push_back(w);
        endfunction

        // accepted input word: advance the frame parser, the retry timer or the link state
        function void take_rx_word(arpr_pkg::req_type_t rt, logic [7:0] b, logic last);
            case (rt)
                arpr_pkg::REQ_RX_BYTE: begin
                    if (rx_pos < 6) begin
                        if (b != regs.local_mac[8*(5-rx_pos) +: 8]) dst_local_ok = 1'b0;
                        if (b != arpr_pkg::BCAST_BYTE) dst_bcast_ok = 1'b0;
                    end else if (rx_pos == 12 || rx_pos == 13) begin
                        rx_ethertype = {rx_ethertype[7:0], b};
                    end else if (rx_pos == 21) begin
                        rx_op = b;
                    end else if (rx_pos >= 22 && rx_pos < 28) begin
                        snd_mac = {snd_mac[39:0], b};
                    end else if (rx_pos >= 28 && rx_pos < 32) begin
                        snd_ip = {snd_ip[23:0], b};
                    end else if (rx_pos >= 38 && rx_pos < 42) begin
                        tgt_ip = {tgt_ip[23:0], b};
                    end
                    if (rx_pos < arpr_pkg::BYTE_IDX_MAX) rx_pos++;
                    if (last) begin
                        if (rx_pos >= arpr_pkg::FRAME_LEN && (dst_local_ok || dst_bcast_ok) &&
                            rx_ethertype == arpr_pkg::ETH_TYPE_ARP) begin
                            if (rx_op == arpr_pkg::ARP_OP_REQUEST &&
                                tgt_ip == regs.local_ip) begin
                                queue_arp_frame(snd_mac, arpr_pkg::ARP_OP_REPLY, snd_mac,
                                                snd_ip);
                            end else if (rx_op == arpr_pkg::ARP_OP_REPLY &&
                                         snd_ip == regs.peer_ip) begin
                                queue_status(arpr_pkg::OUT_PEER_MAC, snd_mac);
                                ctl = arpr_pkg::CTL_RESOLVED;
                            end
                        end
                        rx_pos       = '0;
                        dst_local_ok = 1'b1;
                        dst_bcast_ok = 1'b1;
                    end
                end
                arpr_pkg::REQ_TICK: begin
                    if (ctl == arpr_pkg::CTL_REQUESTING) begin
                        if (ticks_waited != 16'hffff) ticks_waited++;
                        if (ticks_waited >= regs.timeout_ticks) begin
                            if (sends < regs.retry_limit) begin
                                sends++;
                                ticks_waited = '0;
                                queue_arp_frame(arpr_pkg::MAC_BCAST,
                                                arpr_pkg::ARP_OP_REQUEST, 48'd0,
                                                regs.peer_ip);
                            end else begin
                                queue_status(arpr_pkg::OUT_GIVE_UP, 48'd0);
                                ctl = arpr_pkg::CTL_IDLE;
                            end
                        end
                    end
                end
                arpr_pkg::REQ_LINK_UP: begin
                    ctl          = arpr_pkg::CTL_REQUESTING;
                    ticks_waited = '0;
                    sends        = 8'd1;
                    queue_arp_frame(arpr_pkg::MAC_BCAST, arpr_pkg::ARP_OP_REQUEST, 48'd0,
                                    regs.peer_ip);
                end
                default: ctl = arpr_pkg::CTL_IDLE;
            endcase
        endfunction

        // accepted output word against the oldest one due
        function void match_tx_word(logic [1:0] kind, logic [7:0] b, logic last,
                                    logic [47:0] mac);
            tx_word_t w;
            if (tx_words_due.size() == 0) begin
                $error("unexpected result word: out_kind %0d tx_byte %0h", kind, b);
                errors++;
                return;
            end
            w = tx_words_due.pop_front();
            if (kind !== w.kind) begin
                $error("out_kind: expected %0d, got %0d", w.kind, kind);
                errors++;
            end
            if (b !== w.tx_byte) begin
                $error("tx_byte: expected %0h, got %0h", w.tx_byte, b);
                errors++;
            end
            if (last !== w.tx_last) begin
                $error("tx_last: expected %0d, got %0d", w.tx_last, last);
                errors++;
            end
            if (mac !== w.peer_mac) begin
                $error("peer_mac: expected %0h, got %0h", w.peer_mac, mac);
                errors++;
            end
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data  = '0;

    arp_scoreboard sb = new();

    int tx_idle_pct  = 0;   // sender: chance in a hundred to leave a cycle empty
    int rx_stall_pct = 0;   // receiver: chance in a hundred to drop tready
    int holds_asked  = 0;   // bumped by the stimulus to ask for a long hold-off
    int holds_done   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int words_sent   = 0;

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    arp_responder_resolver u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] rx_byte
        .s_tuser   (s_tuser),     // [1:0] req_type
        .s_tlast   (s_tlast),     // rx_last
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] tx_byte, [55:8] peer_mac
        .m_tuser   (m_tuser),     // [1:0] out_kind
        .m_tlast   (m_tlast),     // tx_last
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // receiver: random stalls, or a counted hold-off when one is asked for
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_asked;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // output monitor and handshake-free cycle count
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.match_tx_word(m_tuser, m_tdata[7:0], m_tlast, m_tdata[55:8]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog: nothing moved on any channel for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // writes all five registers back to back, valid drops after the last one
    task automatic program_regs(arpr_pkg::cfg_t c);
        logic [47:0] vals [5];
        logic [2:0]  idxs [5];
        vals = '{c.local_mac, 48'(c.local_ip), 48'(c.peer_ip),
                 48'(c.timeout_ticks), 48'(c.retry_limit)};
        idxs = '{arpr_pkg::CFG_LOCAL_MAC, arpr_pkg::CFG_LOCAL_IP, arpr_pkg::CFG_PEER_IP,
                 arpr_pkg::CFG_TIMEOUT_TICKS, arpr_pkg::CFG_RETRY_LIMIT};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idxs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // offers one word after a random gap and waits for it to be taken
    task automatic send_word(arpr_pkg::req_type_t rt, logic [7:0] b, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rt;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        sb.take_rx_word(rt, b, last);
    endtask

    // sender pause: valid drops, then every due word out plus a margin
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.tx_words_due.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // one received arp frame of len bytes; bytes past 41 are filler
    task automatic send_arp_frame(logic [47:0] dst, logic [15:0] etype, logic [7:0] op,
                                  logic [47:0] smac, logic [31:0] sip, logic [31:0] tip,
                                  int len, bit mix_ticks);
        logic [arpr_pkg::FRAME_LEN*8-1:0] img;
        logic [7:0]                       b;
        img = {dst, 48'({$urandom, $urandom}), etype, 16'($urandom), 16'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom), op, smac, sip,
               48'({$urandom, $urandom}), tip};
        for (int i = 0; i < len; i++) begin
            b = (i < arpr_pkg::FRAME_LEN) ? img[arpr_pkg::FRAME_LEN*8-1-8*i -: 8]
                                          : 8'($urandom);
            // events in mid-frame must not disturb reception
            if (mix_ticks && $urandom_range(9) == 0)
                send_word(arpr_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
            send_word(arpr_pkg::REQ_RX_BYTE, b, i == len - 1);
        end
    endtask

    // one random step: well-formed frames most often, then events, broken frames and noise
    task automatic random_step();
        int          r;
        logic [47:0] dst;
        logic [7:0]  op;
        logic [31:0] sip;
        logic [31:0] tip;
        int          len;
        r   = $urandom_range(99);
        dst = $urandom_range(1) ? sb.regs.local_mac : arpr_pkg::MAC_BCAST;
        op  = $urandom_range(1) ? arpr_pkg::ARP_OP_REQUEST : arpr_pkg::ARP_OP_REPLY;
        if ($urandom_range(15) == 0) op = 8'($urandom);
        sip = ($urandom_range(4) != 0) ? sb.regs.peer_ip : $urandom;
        tip = ($urandom_range(4) != 0) ? sb.regs.local_ip : $urandom;
        len = ($urandom_range(9) == 0) ? $urandom_range(43, 72) : arpr_pkg::FRAME_LEN;
        if (r < 40) begin
            send_arp_frame(dst, arpr_pkg::ETH_TYPE_ARP, op, 48'({$urandom, $urandom}), sip,
                           tip, len, 1'b1);
        end else if (r < 50) begin
            // broken: short, wrong type or foreign destination
            case ($urandom_range(2))
                0: len = $urandom_range(1, arpr_pkg::FRAME_LEN - 1);
                1: dst = 48'({$urandom, $urandom});
                default: ;
            endcase
            send_arp_frame(dst, ($urandom_range(1) ? arpr_pkg::ETH_TYPE_ARP : 16'($urandom)),
                           op, 48'({$urandom, $urandom}), sip, tip, len, 1'b0);
        end else if (r < 68) begin
            repeat ($urandom_range(1, 6))
                send_word(arpr_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
        end else if (r < 76) begin
            send_word(arpr_pkg::REQ_LINK_UP, 8'($urandom), 1'($urandom));
        end else if (r < 81) begin
            send_word(arpr_pkg::REQ_LINK_DOWN, 8'($urandom), 1'($urandom));
        end else begin
            send_word(arpr_pkg::req_type_t'($urandom_range(3)), 8'($urandom),
                      1'($urandom));
        end
    endtask

    function automatic arpr_pkg::cfg_t random_cfg(int max_timeout, int max_retry);
        arpr_pkg::cfg_t c;
        c.local_mac     = 48'({$urandom, $urandom});
        c.local_ip      = $urandom;
        c.peer_ip       = $urandom;
        c.timeout_ticks = 16'($urandom_range(1, max_timeout));
        c.retry_limit   = 8'($urandom_range(1, max_retry));
        return c;
    endfunction

    initial begin
        arpr_pkg::cfg_t cfg_dir;
        int             goal;
        cfg_dir = '{48'h02_00_5e_10_20_30, 32'h0a00_0001, 32'h0a00_00fe, 16'd2, 8'd2};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        program_regs(cfg_dir);
        send_word(arpr_pkg::REQ_TICK, 8'h00, 1'b0);         // ignored while idle
        send_word(arpr_pkg::REQ_LINK_UP, 8'hff, 1'b1);      // broadcast request
        send_word(arpr_pkg::REQ_TICK, 8'hff, 1'b1);
        send_word(arpr_pkg::REQ_TICK, 8'h00, 1'b0);         // timeout: resend
        send_word(arpr_pkg::REQ_TICK, 8'h00, 1'b1);
        send_word(arpr_pkg::REQ_TICK, 8'hff, 1'b0);         // retries used up: give up
        send_word(arpr_pkg::REQ_TICK, 8'h55, 1'b0);         // idle again
        // broadcast request for our address gets a reply
        send_arp_frame(arpr_pkg::MAC_BCAST, arpr_pkg::ETH_TYPE_ARP, arpr_pkg::ARP_OP_REQUEST,
                       48'hffff_ffff_ffff, 32'hffff_ffff, cfg_dir.local_ip,
                       arpr_pkg::FRAME_LEN, 1'b0);
        // long frame past the counter saturation, unicast reply from the peer
        send_arp_frame(cfg_dir.local_mac, arpr_pkg::ETH_TYPE_ARP, arpr_pkg::ARP_OP_REPLY,
                       48'h0, cfg_dir.peer_ip, 32'h0, 70, 1'b0);
        // one byte short: dropped
        send_arp_frame(arpr_pkg::MAC_BCAST, arpr_pkg::ETH_TYPE_ARP, arpr_pkg::ARP_OP_REQUEST,
                       48'h1, 32'h1, cfg_dir.local_ip, arpr_pkg::FRAME_LEN - 1, 1'b0);
        // not an arp ethertype: dropped
        send_arp_frame(arpr_pkg::MAC_BCAST, 16'h0800, arpr_pkg::ARP_OP_REQUEST, 48'h2,
                       32'h2, cfg_dir.local_ip, arpr_pkg::FRAME_LEN, 1'b0);
        send_word(arpr_pkg::REQ_LINK_UP, 8'h00, 1'b0);
        send_word(arpr_pkg::REQ_LINK_DOWN, 8'hff, 1'b1);    // stops the retry timer
        send_word(arpr_pkg::REQ_TICK, 8'h00, 1'b0);
        send_word(arpr_pkg::REQ_TICK, 8'h00, 1'b0);
        wait_drained();

        // phase 1: no idling, register extremes; long receiver hold-off first
        program_regs('{48'hffff_ffff_ffff, 32'h0, 32'hffff_ffff, 16'd1, 8'd255});
        holds_asked <= holds_asked + 1;
        repeat (3) send_word(arpr_pkg::REQ_LINK_UP, 8'($urandom), 1'($urandom));
        wait_drained();
        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal) random_step();
        wait_drained();

        // phase 2: sender mostly idle, opposite extremes
        program_regs('{48'h0, 32'hffff_ffff, 32'h0, 16'd65535, 8'd1});
        tx_idle_pct = 87;
        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal) random_step();
        wait_drained();

        // phase 3: receiver mostly stalling
        program_regs(random_cfg(4, 4));
        tx_idle_pct = 0;
        rx_stall_pct <= 87;
        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal) random_step();
        wait_drained();

        // phase 4: light idling on both sides
        program_regs(random_cfg(3, 6));
        tx_idle_pct = 19;
        rx_stall_pct <= 19;
        goal = words_sent + PHASE_WORDS;
        while (words_sent < goal) random_step();
        wait_drained();

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/arpr_pkg.sv
rtl/arpr_rx.sv
rtl/arpr_tx.sv
rtl/arp_responder_resolver.sv
bench/tb_arp_responder_resolver.sv
